### hdl/dpfr_pkg.sv
// Shared types and constants for the deduplicating packet buffer.
package dpfr_pkg;

  // Store geometry
  localparam int STORE_DEPTH = 64;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W       = IDX_W + 1;

  // Field widths
  localparam int CAP_W   = 7;
  localparam int SRC_W   = 16;
  localparam int DST_W   = 16;
  localparam int TIME_W  = 32;
  localparam int MCNT_W  = 7;
  localparam int ENTRY_W = SRC_W + DST_W + TIME_W;

  localparam int IN_DATA_W  = SRC_W + DST_W + 3 * TIME_W;
  localparam int OUT_DATA_W = ((SRC_W + DST_W + TIME_W + MCNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_FWD  = 2'd1,
    FUNC_CNT  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [SRC_W-1:0]   src;
    logic [DST_W-1:0]   dst;
    logic [TIME_W-1:0]  tim;
    logic [TIME_W-1:0]  lo;
    logic [TIME_W-1:0]  hi;
  } item_t;

  typedef struct packed {
    logic clr;
    logic chk;
  } match_ctl_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
  } ram_req_t;

  typedef struct packed {
    logic load;
    logic ok;
    logic fwd;
    logic cnt;
  } fin_t;

endpackage

### hdl/dpfr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dpfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/dpfr_match.sv
// Compare stage: checks each read entry for duplicates and counts range matches.
module dpfr_match (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dpfr_pkg::match_ctl_t           ctl_i,
  input  dpfr_pkg::item_t                item_i,
  input  logic [dpfr_pkg::ENTRY_W-1:0]   rdata_i,
  output logic                           dup_o,
  output logic [dpfr_pkg::MCNT_W-1:0]    count_o,
  output logic [dpfr_pkg::ENTRY_W-1:0]   entry_o
);
  import dpfr_pkg::*;

  logic                dup_q, dup_d;
  logic [MCNT_W-1:0]   cnt_q, cnt_d;
  logic [ENTRY_W-1:0]  ent_q;
  logic [ENTRY_W-1:0]  key;
  logic [DST_W-1:0]    r_dst;
  logic [TIME_W-1:0]   r_tim;
  logic                hit_dup;
  logic                hit_cnt;

  assign key   = {item_i.src, item_i.dst, item_i.tim};
  assign r_dst = rdata_i[TIME_W +: DST_W];
  assign r_tim = rdata_i[TIME_W-1:0];

  // Compare the entry that came back from the store
  assign hit_dup = (rdata_i == key);
  assign hit_cnt = (r_dst == item_i.dst) && (item_i.lo <= r_tim) && (r_tim <= item_i.hi);

  // Accumulate over the scan
  always_comb begin
    dup_d = dup_q;
    cnt_d = cnt_q;
    if (ctl_i.clr) begin
      dup_d = 1'b0;
      cnt_d = '0;
    end else if (ctl_i.chk) begin
      dup_d = dup_q | hit_dup;
      cnt_d = cnt_q + MCNT_W'(hit_cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      dup_q <= dup_d;
      cnt_q <= cnt_d;
    end
  end

  // Keep the last entry read; for a forward it is the oldest one
  always_ff @(posedge clk_i) begin
    if (ctl_i.chk) begin
      ent_q <= rdata_i;
    end
  end

  assign dup_o   = dup_q;
  assign count_o = cnt_q;
  assign entry_o = ent_q;

endmodule

### hdl/dpfr_ctrl.sv
// Sequencer: ring pointers, capacity register, scan addressing and commit.
module dpfr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dpfr_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                        in_fire_i,
  input  dpfr_pkg::func_e             func_i,
  input  logic                        dup_i,
  input  logic                        out_free_i,
  output logic                        ready_o,
  output dpfr_pkg::match_ctl_t        match_ctl_o,
  output dpfr_pkg::ram_req_t          ram_o,
  output dpfr_pkg::fin_t              fin_o
);
  import dpfr_pkg::*;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [CAP_W-1:0]    cap_q;
  logic [FILL_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic                rd_pend_q;
  logic [FILL_W-1:0]   scan_lim;
  logic [FILL_W-1:0]   eff_lim;
  logic                issue;
  logic                scan_done;
  logic                fin_go;
  logic                is_full;
  logic                add_ok;
  logic                fwd_ok;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = s;
    if (s >= SUM_W'(STORE_DEPTH)) begin
      r = s - SUM_W'(STORE_DEPTH);
    end
    return r[IDX_W-1:0];
  endfunction

  // Clamp the configured limit into 1..STORE_DEPTH
  always_comb begin
    if (cap_q == '0) begin
      eff_lim = FILL_W'(1);
    end else if (int'(cap_q) > STORE_DEPTH) begin
      eff_lim = FILL_W'(STORE_DEPTH);
    end else begin
      eff_lim = FILL_W'(cap_q);
    end
  end

  // Number of entries to read for this operation
  always_comb begin
    unique case (func_i)
      FUNC_ADD, FUNC_CNT: scan_lim = fill_q;
      FUNC_FWD:           scan_lim = (fill_q != '0) ? FILL_W'(1) : '0;
      FUNC_NONE:          scan_lim = '0;
    endcase
  end

  assign issue     = (state_q == ST_SCAN) && (rd_cnt_q < scan_lim);
  assign scan_done = (state_q == ST_SCAN) && (rd_cnt_q == scan_lim) && !rd_pend_q;
  assign fin_go    = (state_q == ST_FIN) && out_free_i;
  assign is_full   = (fill_q >= eff_lim) && (fill_q != '0);
  assign add_ok    = (func_i == FUNC_ADD) && !dup_i;
  assign fwd_ok    = (func_i == FUNC_FWD) && (fill_q != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire_i) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_FIN;
      ST_FIN:  if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ready_o         = (state_q == ST_IDLE);
    match_ctl_o.clr = in_fire_i;
    match_ctl_o.chk = rd_pend_q;
    ram_o.re        = issue;
    ram_o.raddr     = wrap_idx(SUM_W'(head_q) + SUM_W'(rd_cnt_q));
    ram_o.we        = fin_go && add_ok;
    ram_o.waddr     = wrap_idx(SUM_W'(head_q) + SUM_W'(fill_q));
    fin_o.load      = fin_go;
    fin_o.ok        = add_ok || fwd_ok;
    fin_o.fwd       = fwd_ok;
    fin_o.cnt       = (func_i == FUNC_CNT);
  end

  // Advance the scan counter
  always_comb begin
    rd_cnt_d = rd_cnt_q;
    if (in_fire_i) begin
      rd_cnt_d = '0;
    end else if (issue) begin
      rd_cnt_d = rd_cnt_q + FILL_W'(1);
    end
  end

  // Commit ring pointer changes at the end of the operation
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (fin_go && add_ok) begin
      if (is_full) begin
        head_d = wrap_idx(SUM_W'(head_q) + SUM_W'(1));
      end else begin
        fill_d = fill_q + FILL_W'(1);
      end
    end else if (fin_go && fwd_ok) begin
      head_d = wrap_idx(SUM_W'(head_q) + SUM_W'(1));
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      fill_q    <= '0;
      cap_q     <= CAP_W'(STORE_DEPTH);
      rd_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_pend_q <= issue;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

endmodule

### hdl/dedup_packet_fifo_router_unit.sv
// Top level of the deduplicating bounded packet buffer.
// Takes one beat at a time. An add or a count reads every buffered entry, one per
// cycle, through the single read port of the entry store; a forward reads only
// the oldest entry. The next beat can be taken in the cycle after the result is
// loaded. The result sits in an output register, so the block returns to accept
// the next beat while the result waits, and stalls only if a new result is ready
// before the last one is taken. Adds reject exact copies of buffered packets and
// evict the oldest when full.
module dedup_packet_fifo_router_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpfr_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // pkt_source, pkt_dest, pkt_time, range_start, range_end (low bit first)
  input  logic [dpfr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // func
  input  logic [1:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out_source, out_dest, out_time, match_count, zero pad (low bit first)
  output logic [dpfr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // ok
  output logic                            m_axis_tuser_o
);
  import dpfr_pkg::*;

  item_t               item_q;
  logic                in_fire;
  logic                out_free;
  logic                out_vld_q;
  logic                ok_q;
  logic [SRC_W-1:0]    osrc_q;
  logic [DST_W-1:0]    odst_q;
  logic [TIME_W-1:0]   otim_q;
  logic [MCNT_W-1:0]   ocnt_q;
  match_ctl_t          match_ctl;
  ram_req_t            ram_req;
  fin_t                fin;
  logic [ENTRY_W-1:0]  rdata;
  logic [ENTRY_W-1:0]  entry;
  logic [MCNT_W-1:0]   mcount;
  logic                dup;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;

  // Capture the input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (in_fire) begin
      item_q.func <= func_e'(s_axis_tuser_i);
      item_q.src  <= s_axis_tdata_i[0 +: SRC_W];
      item_q.dst  <= s_axis_tdata_i[SRC_W +: DST_W];
      item_q.tim  <= s_axis_tdata_i[SRC_W + DST_W +: TIME_W];
      item_q.lo   <= s_axis_tdata_i[SRC_W + DST_W + TIME_W +: TIME_W];
      item_q.hi   <= s_axis_tdata_i[SRC_W + DST_W + 2 * TIME_W +: TIME_W];
    end
  end

  dpfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .func_i      (item_q.func),
    .dup_i       (dup),
    .out_free_i  (out_free),
    .ready_o     (s_axis_tready_o),
    .match_ctl_o (match_ctl),
    .ram_o       (ram_req),
    .fin_o       (fin)
  );

  dpfr_ram #(
    .Width (ENTRY_W),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i ({item_q.src, item_q.dst, item_q.tim}),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  dpfr_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (match_ctl),
    .item_i  (item_q),
    .rdata_i (rdata),
    .dup_o   (dup),
    .count_o (mcount),
    .entry_o (entry)
  );

  // Output valid: set on a new result, drop once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin.load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output payload: zero every field the operation does not return
  always_ff @(posedge clk_i) begin
    if (fin.load) begin
      ok_q   <= fin.ok;
      osrc_q <= fin.fwd ? entry[TIME_W + DST_W +: SRC_W] : '0;
      odst_q <= fin.fwd ? entry[TIME_W +: DST_W] : '0;
      otim_q <= fin.fwd ? entry[TIME_W-1:0] : '0;
      ocnt_q <= fin.cnt ? mcount : '0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = ok_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({ocnt_q, otim_q, odst_q, osrc_q});

  // A result is loaded only when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.load |-> out_free)
    else $error("result loaded over a pending output beat");

  // The store is written only while no beat can be accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> !s_axis_tready_o)
    else $error("store write while accepting input");

  // An accepted beat closes the input until its work is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("input reopened right after accept");

  // A count never exceeds the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin.load && fin.cnt) |-> (int'(mcount) <= STORE_DEPTH))
    else $error("match count above store depth");

endmodule
